// ===== rtl/core/least_loaded_server_dispatch_core_assert.svh =====
// Assertion macros for the least-loaded server dispatch core.
// No dependencies; taken in by `include in the files that assert.
`ifndef LEAST_LOADED_SERVER_DISPATCH_CORE_ASSERT_SVH
`define LEAST_LOADED_SERVER_DISPATCH_CORE_ASSERT_SVH

`ifndef SYNTH

// Condition implies consequence in the same cycle
`define LLSD_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("llsd assertion failed");

// Condition implies consequence in the next cycle
`define LLSD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("llsd assertion failed");

`else

`define LLSD_ASSERT_NOW(label, clk, rst, ante, cons)
`define LLSD_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ===== rtl/core/llsd_pkg.sv =====
// Shared types and fixed widths for the least-loaded server dispatch core.
// No dependencies.
`timescale 1ns / 1ps

package llsd_pkg;

   // Field widths fixed by the interface
   localparam int JOB_W      = 16;
   localparam int TIME_W     = 26;
   localparam int SUM_W      = 36;
   localparam int AVG_W      = 34;
   localparam int FRAC_W     = 8;
   localparam int IDX_OUT_W  = 4;
   localparam int CFG_W      = 5;

   // Average divider: dividend is the wait sum with fractional bits appended
   localparam int DVD_W      = SUM_W + FRAC_W;
   localparam int DIV_CNT_W  = 6;

   // Configuration port
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic [CSR_ADDR_W-3:0] REG_SERVERS_IN_USE = 1'd0;
   localparam logic [CFG_W-1:0] SERVERS_RESET = 5'd1;

   // Saturation limits
   localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};
   localparam logic [SUM_W-1:0]  SUM_MAX  = {SUM_W{1'b1}};
   localparam logic [AVG_W-1:0]  AVG_MAX  = {AVG_W{1'b1}};

   typedef struct packed {
      logic [JOB_W-1:0] job_time;
      logic             last_job;
   } req_payload_type;

   typedef struct packed {
      logic [IDX_OUT_W-1:0] server_index;
      logic [TIME_W-1:0]    finish_time;
      logic [TIME_W-1:0]    wait_time;
      logic                 batch_done;
      logic [TIME_W-1:0]    makespan;
      logic [AVG_W-1:0]     average_wait;
      logic                 overflow;
   } rsp_payload_type;

endpackage

// ===== rtl/core/least_loaded_server_dispatch_core.sv =====
// Least-loaded server dispatch: sequencer, load memory, scan comparator and
// restoring divider for the batch average. Depends on llsd_pkg and the
// assertion macro header.
`timescale 1ns / 1ps

// Each job goes to the active server with the smallest accumulated load (ties
// to the lowest index); the result gives the server, finish time and wait.
// Loads sit in a memory with one registered read port, and one comparator
// walks the active servers one per cycle; an ordinary job then passes the
// add, wait, sum and output states. The job marked last also runs the
// bit-serial division of the wait sum by the job count (44 quotient bits,
// one per cycle). Results go to an output register, so the next job is taken
// while a result waits.
// Batch-end clearing of the loads happens at once through per-entry valid
// bits; there is no clearing pass after reset.

`include "least_loaded_server_dispatch_core_assert.svh"

module least_loaded_server_dispatch_core
   import llsd_pkg::*;
#(
   parameter int MAX_SERVERS = 16,
   parameter int MAX_JOBS    = 1024
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_payload_type       req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_payload_type       rsp_data,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   localparam int IDX_W = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1;
   localparam int CNT_W = $clog2(MAX_SERVERS + 1);
   localparam int JC_W  = $clog2(MAX_JOBS + 1);
   localparam logic [JC_W-1:0] JOBS_LIMIT = JC_W'(MAX_JOBS);
   localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DVD_W - 1);

   // Sequencer states
   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_SCAN  = 4'd1;
   localparam logic [3:0] ST_ADD   = 4'd2;
   localparam logic [3:0] ST_WAIT  = 4'd3;
   localparam logic [3:0] ST_SUM   = 4'd4;
   localparam logic [3:0] ST_DINIT = 4'd5;
   localparam logic [3:0] ST_DIV   = 4'd6;
   localparam logic [3:0] ST_DFIN  = 4'd7;
   localparam logic [3:0] ST_OUT   = 4'd8;

   // Control registers
   logic [3:0]             state_ff, state_in;
   logic [CFG_W-1:0]       srv_cfg_ff, srv_cfg_in;
   logic [CNT_W-1:0]       n_ff, n_in;
   logic [CNT_W-1:0]       rd_idx_ff, rd_idx_in;
   logic                   data_live_ff, data_live_in;
   logic [MAX_SERVERS-1:0] load_vld_ff, load_vld_in;
   logic [TIME_W-1:0]      max_finish_ff, max_finish_in;
   logic [SUM_W-1:0]       wait_sum_ff, wait_sum_in;
   logic [JC_W-1:0]        job_count_ff, job_count_in;
   logic                   ovf_ff, ovf_in;
   logic [DIV_CNT_W-1:0]   div_cnt_ff, div_cnt_in;
   logic                   rsp_valid_ff, rsp_valid_in;

   // Payload registers
   logic [JOB_W-1:0]       job_ff, job_in;
   logic                   last_ff, last_in;
   logic [IDX_W-1:0]       data_idx_ff, data_idx_in;
   logic [IDX_W-1:0]       best_ff, best_in;
   logic [TIME_W-1:0]      best_load_ff, best_load_in;
   logic [TIME_W-1:0]      finish_ff, finish_in;
   logic [TIME_W-1:0]      wait_ff, wait_in;
   logic [DVD_W-1:0]       dq_ff, dq_in;
   logic [JC_W-1:0]        rem_ff, rem_in;
   logic [AVG_W-1:0]       avg_ff, avg_in;
   rsp_payload_type        rsp_data_ff, rsp_data_in;

   // Load memory with registered read
   logic [TIME_W-1:0]      load_mem [MAX_SERVERS];
   logic [TIME_W-1:0]      rdata_ff;
   logic                   rvalid_ff;

   logic                   req_xfer;
   logic                   csr_wr;
   logic                   rd_en;
   logic                   mem_wr;
   logic [CNT_W-1:0]       n_last;
   logic [TIME_W-1:0]      cand_load;
   logic [TIME_W:0]        load_sum;
   logic [TIME_W-1:0]      finish_sat;
   logic [SUM_W:0]         wsum_add;
   logic [JC_W:0]          rem_shift;
   logic [JC_W:0]          rem_diff;
   logic                   rem_ge;
   logic                   out_load;

   assign req_xfer   = req_valid && !req_stall;
   assign req_stall  = (state_ff != ST_IDLE);
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite
                       && (csr_paddr[CSR_ADDR_W-1:2] == REG_SERVERS_IN_USE);
   assign csr_prdata = CSR_DATA_W'(srv_cfg_ff);

   // Scan datapath: one read issued per cycle, compared in the cycle after
   assign rd_en     = (state_ff == ST_SCAN) && (rd_idx_ff < n_ff);
   assign n_last    = n_ff - CNT_W'(1);
   assign cand_load = rvalid_ff ? rdata_ff : '0;

   // Load add with saturation
   assign load_sum   = (TIME_W+1)'(best_load_ff) + (TIME_W+1)'(job_ff);
   assign finish_sat = load_sum[TIME_W] ? TIME_MAX : load_sum[TIME_W-1:0];
   assign mem_wr     = (state_ff == ST_ADD);

   assign wsum_add = (SUM_W+1)'(wait_sum_ff) + (SUM_W+1)'(wait_ff);

   // Restoring divider step
   assign rem_shift = {rem_ff, dq_ff[DVD_W-1]};
   assign rem_diff  = rem_shift - {1'b0, job_count_ff};
   assign rem_ge    = (rem_shift >= {1'b0, job_count_ff});

   assign out_load  = (state_ff == ST_OUT) && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      state_in      = state_ff;
      srv_cfg_in    = csr_wr ? csr_pwdata[CFG_W-1:0] : srv_cfg_ff;
      n_in          = n_ff;
      rd_idx_in     = rd_idx_ff;
      data_live_in  = rd_en;
      data_idx_in   = rd_idx_ff[IDX_W-1:0];
      load_vld_in   = load_vld_ff;
      max_finish_in = max_finish_ff;
      wait_sum_in   = wait_sum_ff;
      job_count_in  = job_count_ff;
      ovf_in        = ovf_ff;
      div_cnt_in    = div_cnt_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      job_in        = job_ff;
      last_in       = last_ff;
      best_in       = best_ff;
      best_load_in  = best_load_ff;
      finish_in     = finish_ff;
      wait_in       = wait_ff;
      dq_in         = dq_ff;
      rem_in        = rem_ff;
      avg_in        = avg_ff;
      rsp_data_in   = rsp_data_ff;
      if (rd_en) begin
         rd_idx_in = rd_idx_ff + CNT_W'(1);
      end
      case (state_ff)
         ST_IDLE: begin
            // Take the job and clamp the active server count
            if (req_xfer) begin
               job_in    = req_data.job_time;
               last_in   = req_data.last_job;
               rd_idx_in = '0;
               if (srv_cfg_ff == '0) begin
                  n_in = CNT_W'(1);
               end else if (32'(srv_cfg_ff) > MAX_SERVERS) begin
                  n_in = CNT_W'(MAX_SERVERS);
               end else begin
                  n_in = CNT_W'(srv_cfg_ff);
               end
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            // Keep the first strictly smaller load; index 0 seeds the search
            if (data_live_ff) begin
               if ((data_idx_ff == '0) || (cand_load < best_load_ff)) begin
                  best_in      = data_idx_ff;
                  best_load_in = cand_load;
               end
               if (data_idx_ff == n_last[IDX_W-1:0]) begin
                  state_in = ST_ADD;
               end
            end
         end
         ST_ADD: begin
            finish_in = finish_sat;
            load_vld_in[best_ff] = 1'b1;
            if (load_sum[TIME_W]) begin
               ovf_in = 1'b1;
            end
            state_in = ST_WAIT;
         end
         ST_WAIT: begin
            wait_in = finish_ff - TIME_W'(job_ff);
            if (finish_ff > max_finish_ff) begin
               max_finish_in = finish_ff;
            end
            state_in = ST_SUM;
         end
         ST_SUM: begin
            // Accumulate wait and count the job, both saturating
            if (wsum_add[SUM_W]) begin
               wait_sum_in = SUM_MAX;
               ovf_in      = 1'b1;
            end else begin
               wait_sum_in = wsum_add[SUM_W-1:0];
            end
            if (job_count_ff < JOBS_LIMIT) begin
               job_count_in = job_count_ff + JC_W'(1);
            end else begin
               ovf_in = 1'b1;
            end
            avg_in   = '0;
            state_in = last_ff ? ST_DINIT : ST_OUT;
         end
         ST_DINIT: begin
            dq_in      = {wait_sum_ff, {FRAC_W{1'b0}}};
            rem_in     = '0;
            div_cnt_in = '0;
            state_in   = ST_DIV;
         end
         ST_DIV: begin
            // One quotient bit per cycle
            rem_in     = rem_ge ? rem_diff[JC_W-1:0] : rem_shift[JC_W-1:0];
            dq_in      = {dq_ff[DVD_W-2:0], rem_ge};
            div_cnt_in = div_cnt_ff + DIV_CNT_W'(1);
            if (div_cnt_ff == DIV_LAST) begin
               state_in = ST_DFIN;
            end
         end
         ST_DFIN: begin
            if (|dq_ff[DVD_W-1:AVG_W]) begin
               avg_in = AVG_MAX;
               ovf_in = 1'b1;
            end else begin
               avg_in = dq_ff[AVG_W-1:0];
            end
            state_in = ST_OUT;
         end
         ST_OUT: begin
            // Hand the result to the output register, then clear on batch end
            if (out_load) begin
               rsp_valid_in              = 1'b1;
               rsp_data_in.server_index  = IDX_OUT_W'(best_ff);
               rsp_data_in.finish_time   = finish_ff;
               rsp_data_in.wait_time     = wait_ff;
               rsp_data_in.batch_done    = last_ff;
               rsp_data_in.makespan      = last_ff ? max_finish_ff : '0;
               rsp_data_in.average_wait  = avg_ff;
               rsp_data_in.overflow      = ovf_ff;
               if (last_ff) begin
                  load_vld_in   = '0;
                  max_finish_in = '0;
                  wait_sum_in   = '0;
                  job_count_in  = '0;
                  ovf_in        = 1'b0;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         srv_cfg_ff    <= SERVERS_RESET;
         n_ff          <= CNT_W'(1);
         rd_idx_ff     <= '0;
         data_live_ff  <= 1'b0;
         load_vld_ff   <= '0;
         max_finish_ff <= '0;
         wait_sum_ff   <= '0;
         job_count_ff  <= '0;
         ovf_ff        <= 1'b0;
         div_cnt_ff    <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         srv_cfg_ff    <= srv_cfg_in;
         n_ff          <= n_in;
         rd_idx_ff     <= rd_idx_in;
         data_live_ff  <= data_live_in;
         load_vld_ff   <= load_vld_in;
         max_finish_ff <= max_finish_in;
         wait_sum_ff   <= wait_sum_in;
         job_count_ff  <= job_count_in;
         ovf_ff        <= ovf_in;
         div_cnt_ff    <= div_cnt_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      job_ff       <= job_in;
      last_ff      <= last_in;
      data_idx_ff  <= data_idx_in;
      best_ff      <= best_in;
      best_load_ff <= best_load_in;
      finish_ff    <= finish_in;
      wait_ff      <= wait_in;
      dq_ff        <= dq_in;
      rem_ff       <= rem_in;
      avg_ff       <= avg_in;
      rsp_data_ff  <= rsp_data_in;
   end

   // Load memory: write the chosen server, read the scan address
   always_ff @(posedge clock) begin
      if (mem_wr) begin
         load_mem[best_ff] <= finish_sat;
      end
      if (rd_en) begin
         rdata_ff  <= load_mem[rd_idx_ff[IDX_W-1:0]];
         rvalid_ff <= load_vld_ff[rd_idx_ff[IDX_W-1:0]];
      end
   end

   // Checks
   `LLSD_ASSERT_NEXT(a_accept_starts_scan, clock, reset, req_xfer, state_ff == ST_SCAN)
   `LLSD_ASSERT_NOW(a_scan_in_range, clock, reset, state_ff == ST_SCAN,
      (rd_idx_ff <= n_ff) && (n_ff != '0) && (32'(n_ff) <= MAX_SERVERS))
   `LLSD_ASSERT_NOW(a_best_active, clock, reset, state_ff == ST_ADD,
      32'(best_ff) < 32'(n_ff))
   `LLSD_ASSERT_NEXT(a_batch_cleared, clock, reset, out_load && last_ff,
      (job_count_ff == '0) && !ovf_ff && (load_vld_ff == '0) && (wait_sum_ff == '0))

endmodule

// ===== tb/least_loaded_server_dispatch_core_tb.sv =====
// Testbench for least_loaded_server_dispatch_core: drives jobs and register writes,
// predicts each dispatch result and compares it field by field.
// Depends on llsd_pkg and the core RTL.
`timescale 1ns / 1ps

module least_loaded_server_dispatch_core_tb;
   import llsd_pkg::*;

   localparam int SERVER_SLOTS = 16;
   localparam int JOB_CAP      = 1024;
   localparam int SETTLE_CYCLES = 80;
   localparam int CYCLE_LIMIT  = 2000000;
   localparam int HOLD_CYCLES  = 500;
   localparam logic [CSR_ADDR_W-1:0] SERVERS_ADDR = {REG_SERVERS_IN_USE, 2'b00};

   // Greedy least-loaded dispatch predictor plus the queue of pending results
   class dispatch_scoreboard;
      bit [CFG_W-1:0]  servers_cfg;
      bit [TIME_W-1:0] loads[SERVER_SLOTS];
      bit [TIME_W-1:0] peak_finish;
      bit [SUM_W-1:0]  wait_total;
      bit [10:0]       jobs_seen;
      bit              sat_seen;
      rsp_payload_type expected_results[$];
      int              mismatches;

      function new();
         servers_cfg = SERVERS_RESET;
         mismatches  = 0;
         clear_batch();
      endfunction

      function void clear_batch();
         foreach (loads[s]) loads[s] = '0;
         peak_finish = '0;
         wait_total  = '0;
         jobs_seen   = '0;
         sat_seen    = 1'b0;
      endfunction

      function void set_servers(bit [CFG_W-1:0] value);
         servers_cfg = value;
      endfunction

      function int pending();
         return expected_results.size();
      endfunction

      function void flag(string msg);
         mismatches++;
         if (mismatches <= 10) $display("mismatch: %s", msg);
      endfunction

      // Work out the dispatch for one accepted job and queue it
      function void note_job(req_payload_type job);
         int active;
         int best;
         logic [TIME_W:0]    raw_finish;
         logic [SUM_W:0]     raw_sum;
         logic [DVD_W-1:0]   quotient;
         logic [TIME_W-1:0]  finish;
         rsp_payload_type    r;
         active = (servers_cfg == '0) ? 1 :
                  (int'(servers_cfg) > SERVER_SLOTS) ? SERVER_SLOTS : int'(servers_cfg);
         best = 0;
         for (int s = 1; s < active; s++)
            if (loads[s] < loads[best]) best = s;
         raw_finish = {1'b0, loads[best]} + (TIME_W+1)'(job.job_time);
         if (raw_finish > {1'b0, TIME_MAX}) begin
            finish   = TIME_MAX;
            sat_seen = 1'b1;
         end else begin
            finish = raw_finish[TIME_W-1:0];
         end
         loads[best] = finish;
         r = '0;
         r.server_index = best[IDX_OUT_W-1:0];
         r.finish_time  = finish;
         r.wait_time    = finish - TIME_W'(job.job_time);
         if (finish > peak_finish) peak_finish = finish;
         raw_sum = {1'b0, wait_total} + (SUM_W+1)'(r.wait_time);
         if (raw_sum > {1'b0, SUM_MAX}) begin
            wait_total = SUM_MAX;
            sat_seen   = 1'b1;
         end else begin
            wait_total = raw_sum[SUM_W-1:0];
         end
         if (jobs_seen < 11'(JOB_CAP)) jobs_seen++;
         else sat_seen = 1'b1;
         r.batch_done = job.last_job;
         if (job.last_job) begin
            quotient = {wait_total, {FRAC_W{1'b0}}} / DVD_W'(jobs_seen);
            if (quotient > DVD_W'(AVG_MAX)) begin
               r.average_wait = AVG_MAX;
               sat_seen       = 1'b1;
            end else begin
               r.average_wait = quotient[AVG_W-1:0];
            end
            r.makespan = peak_finish;
         end
         r.overflow = sat_seen;
         expected_results.push_back(r);
         if (job.last_job) clear_batch();
      endfunction

      function void compare_field(string name, longint unsigned want, longint unsigned got);
         if (want != got) flag($sformatf("%s expected %0d, got %0d", name, want, got));
      endfunction

      // Compare one result transfer with the oldest expectation
      function void check_result(rsp_payload_type got);
         rsp_payload_type want;
         if (expected_results.size() == 0) begin
            flag($sformatf("result with nothing pending: server %0d finish %0d",
                           got.server_index, got.finish_time));
            return;
         end
         want = expected_results.pop_front();
         compare_field("server_index", 64'(want.server_index), 64'(got.server_index));
         compare_field("finish_time", 64'(want.finish_time), 64'(got.finish_time));
         compare_field("wait_time", 64'(want.wait_time), 64'(got.wait_time));
         compare_field("batch_done", 64'(want.batch_done), 64'(got.batch_done));
         compare_field("makespan", 64'(want.makespan), 64'(got.makespan));
         compare_field("average_wait", 64'(want.average_wait), 64'(got.average_wait));
         compare_field("overflow", 64'(want.overflow), 64'(got.overflow));
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   req_payload_type       req_data = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   rsp_payload_type       rsp_data;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   dispatch_scoreboard sb = new();
   bit no_idle = 1'b0;
   bit hold_request = 1'b0;
   int cycle_count = 0;

   least_loaded_server_dispatch_core u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #4 clock = ~clock;

   // Abort a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // Take result transfers; stall at random, or hold off for a long stretch on request
   initial begin : result_side
      int hold_left;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) sb.check_result(rsp_data);
         if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= !no_idle && ($urandom_range(0, 99) < 10);
         end
      end
   end

   // Offer one job and wait for its transfer; valid stays high into the next job
   task automatic send_job(input logic [JOB_W-1:0] duration, input logic last);
      req_payload_type job;
      job.job_time = duration;
      job.last_job = last;
      while (!no_idle && $urandom_range(0, 99) < 10) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= job;
      do @(posedge clock); while (req_stall);
      sb.note_job(job);
   endtask

   // Drop the request, let every pending result drain, then give the block time to go idle
   task automatic settle();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_access(input logic write, input logic [CSR_DATA_W-1:0] wdata,
                             output logic [CSR_DATA_W-1:0] rdata);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= write;
      csr_paddr   <= SERVERS_ADDR;
      csr_pwdata  <= wdata;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      rdata = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // Write the server count with random upper bits, then read it back
   task automatic set_servers(input int count);
      logic [CSR_DATA_W-1:0] wdata;
      logic [CSR_DATA_W-1:0] rdata;
      wdata = $urandom;
      wdata[CFG_W-1:0] = count[CFG_W-1:0];
      settle();
      csr_access(1'b1, wdata, rdata);
      sb.set_servers(wdata[CFG_W-1:0]);
      csr_access(1'b0, '0, rdata);
      if (rdata[CFG_W-1:0] !== wdata[CFG_W-1:0])
         sb.flag($sformatf("servers_in_use readback expected %0d, got %0d",
                           wdata[CFG_W-1:0], rdata[CFG_W-1:0]));
   endtask

   // Random jobs under one server count; batches end at random
   task automatic run_phase(input int count, input int jobs, input bit calm, input bit press);
      logic [JOB_W-1:0] duration;
      int pick;
      set_servers(count);
      no_idle = calm;
      if (press) hold_request = 1'b1;
      for (int i = 0; i < jobs; i++) begin
         pick = $urandom_range(0, 9);
         case (pick)
            0: duration = '0;
            1: duration = '1;
            2, 3, 4: duration = JOB_W'($urandom_range(0, 15));
            default: duration = JOB_W'($urandom);
         endcase
         send_job(duration, $urandom_range(0, 9) == 0);
      end
      no_idle = 1'b0;
   endtask

   initial begin : stimulus
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Reset count of one server
      send_job(16'd10, 1'b0);
      send_job(16'd20, 1'b1);

      // Ties across four servers, field extremes and bit patterns
      set_servers(4);
      send_job(16'd0, 1'b0);
      send_job(16'hFFFF, 1'b0);
      send_job(16'hAAAA, 1'b0);
      send_job(16'h5555, 1'b0);
      send_job(16'd1, 1'b0);
      send_job(16'd0, 1'b1);
      // Batch of a single job
      send_job(16'd7, 1'b1);

      // Zero acts as one server, values above the slot count act as the slot count
      set_servers(0);
      send_job(16'd5, 1'b0);
      send_job(16'd3, 1'b1);
      set_servers(31);
      send_job(16'd9, 1'b0);
      send_job(16'd9, 1'b0);
      send_job(16'd9, 1'b1);
      set_servers(17);
      send_job(16'd2, 1'b1);

      // Change the count in the middle of a batch
      set_servers(16);
      send_job(16'd100, 1'b0);
      send_job(16'd50, 1'b0);
      send_job(16'd25, 1'b0);
      set_servers(2);
      send_job(16'd4, 1'b0);
      send_job(16'd4, 1'b1);

      // Long batch on one server: saturate the load, the job count and the wait sum
      set_servers(1);
      for (int i = 0; i < 1600; i++)
         send_job((i < 1100) ? 16'hFFFF : JOB_W'($urandom), i == 1599);

      run_phase(16, 80, 1'b0, 1'b0);
      run_phase(1, 40, 1'b0, 1'b0);
      run_phase(3, 60, 1'b1, 1'b0);
      run_phase(16, 100, 1'b1, 1'b1);
      run_phase(0, 20, 1'b0, 1'b0);
      run_phase(31, 30, 1'b0, 1'b0);
      run_phase($urandom_range(2, 15), 30, 1'b0, 1'b0);
      run_phase(8, 20, 1'b0, 1'b0);
      run_phase(16, 20, 1'b0, 1'b0);
      req_valid <= 1'b0;

      settle();
      if (sb.mismatches == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
